// ===== rtl/str_pkg.sv =====
// ============================================================================
// str_pkg
// Shared types and constants of the stepper trapezoid ramp unit: command
// codes, motion phases, register indexes, reset values and field widths.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package str_pkg;

    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned STEPS_W  = 31;
    localparam int unsigned POS_W    = 32;
    localparam int unsigned CFG_IDX_W = 8;

    // Command codes carried in the kind field.
    typedef enum logic [2:0] {
        K_TICK      = 3'd0,
        K_MOVE      = 3'd1,
        K_HARD_STOP = 3'd2,
        K_SOFT_STOP = 3'd3,
        K_SET_DIR   = 3'd4,
        K_LOAD_POS  = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_ACCEL  = 3'd1,
        PH_STEADY = 3'd2,
        PH_DECEL  = 3'd3,
        PH_STOP   = 3'd4
    } t_phase;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_PERIOD  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_PERIOD = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STEP    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DECEL_STEP    = 8'd3;

    localparam logic [PERIOD_W-1:0] RST_START_PERIOD  = 16'd64000;
    localparam logic [PERIOD_W-1:0] RST_TARGET_PERIOD = 16'd16000;
    localparam logic [PERIOD_W-1:0] RST_ACCEL_STEP    = 16'd1000;
    localparam logic [PERIOD_W-1:0] RST_DECEL_STEP    = 16'd1000;

endpackage

`default_nettype wire

// ===== rtl/str_div.sv =====
// ============================================================================
// str_div
// Bit-serial restoring divider. The dividend shifts out one bit per cycle
// while the quotient shifts in; one subtract and compare per cycle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module str_div #(
    parameter int unsigned WIDTH = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [WIDTH-1:0] i_dividend,
    input  wire logic [WIDTH-1:0] i_divisor,
    output logic                  o_done,
    output logic [WIDTH-1:0]      o_quotient
);

    localparam int unsigned CNT_W = $clog2(WIDTH + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [WIDTH:0]   r_rem;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_dvs;

    logic [WIDTH:0]   shifted;
    logic [WIDTH+1:0] diff;

    always_comb begin
        shifted = {r_rem[WIDTH-1:0], r_quo[WIDTH-1]};
        diff    = {1'b0, shifted} - {2'b00, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!diff[WIDTH+1]) begin
                r_rem <= diff[WIDTH:0];
                r_quo <= {r_quo[WIDTH-2:0], 1'b1};
            end else begin
                r_rem <= shifted;
                r_quo <= {r_quo[WIDTH-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== rtl/stepper_trapezoid_ramp_unit.sv =====
// ============================================================================
// stepper_trapezoid_ramp_unit
// Trapezoidal step-period ramp generator for a stepper motor, with a
// bit-serial divider for the braking distance.
// ============================================================================
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------------
//   in      | input     | i_in_valid / o_in_stall   | i_kind, i_step_count,
//           |           |                           | i_forward, i_position_value
//   out     | output    | o_out_valid / i_out_stall | o_period, o_generator_on,
//           |           |                           | o_phase, o_position, o_steps_left
//   cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A soft stop, and a step tick while cruising, run the braking distance
// through the serial divider before the result is applied; every other
// command goes from acceptance straight to the apply state.
// A new command is taken in the cycle after the previous result is committed.
// A stalled result holds; the state commits only when the output is free.
// Reset is synchronous and active low; no clearing pass follows it.
`timescale 1ns / 1ps
`default_nettype none

module stepper_trapezoid_ramp_unit #(
    parameter int unsigned STOP_PERIOD = 64000
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_kind,
    input  wire logic [30:0] i_step_count,
    input  wire logic        i_forward,
    input  wire logic signed [31:0] i_position_value,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_period,
    output logic             o_generator_on,
    output logic [2:0]       o_phase,
    output logic signed [31:0] o_position,
    output logic [30:0]      o_steps_left,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam int unsigned PW = str_pkg::PERIOD_W;
    localparam int unsigned SW = str_pkg::STEPS_W;
    localparam int unsigned QW = str_pkg::POS_W;
    localparam logic [PW-1:0] L_STOP = PW'(STOP_PERIOD);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_APPLY
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [PW-1:0] r_start;
    logic [PW-1:0] r_target;
    logic [PW-1:0] r_accel;
    logic [PW-1:0] r_decel;

    // Motion state; it doubles as the output register.
    logic [SW-1:0]     r_steps;
    logic [PW-1:0]     r_period;
    str_pkg::t_phase   r_phase;
    logic              r_fwd;
    logic [QW-1:0]     r_pos;
    logic              r_running;
    logic              r_out_valid;

    // Latched command.
    logic [2:0]    r_kind;
    logic [SW-1:0] r_count;
    logic          r_cmd_fwd;
    logic [QW-1:0] r_cmd_pos;

    logic [SW-1:0]   n_steps;
    logic [PW-1:0]   n_period;
    str_pkg::t_phase n_phase;
    logic            n_fwd;
    logic [QW-1:0]   n_pos;
    logic            n_running;

    logic            accept;
    logic            needs_div;
    logic            div_start;
    logic            div_done;
    logic [PW-1:0]   div_quo;
    logic            out_free;
    logic            commit;
    logic [PW-1:0]   brake;
    logic [PW:0]     accel_floor;
    logic [PW:0]     decel_sum;
    str_pkg::t_phase ph_mid;

    assign accept    = i_in_valid && !o_in_stall;
    assign needs_div = (i_kind == str_pkg::K_SOFT_STOP) ||
                       ((i_kind == str_pkg::K_TICK) && (r_phase == str_pkg::PH_STEADY));
    assign div_start = accept && needs_div;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign commit    = (r_state == S_APPLY) && out_free;

    str_div #(
        .WIDTH (PW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (L_STOP - r_period),
        .i_divisor  (r_decel),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_steps     = r_steps;
        n_period    = r_period;
        n_phase     = r_phase;
        n_fwd       = r_fwd;
        n_pos       = r_pos;
        n_running   = r_running;
        ph_mid      = r_phase;
        accel_floor = {1'b0, r_target} + {1'b0, r_accel};
        decel_sum   = {1'b0, r_period} + {1'b0, r_decel};

        // Braking distance is zero at or above the stop period, or with no decel.
        if ((r_period >= L_STOP) || (r_decel == '0)) begin
            brake = '0;
        end else begin
            brake = div_quo;
        end

        unique case (r_kind)
            str_pkg::K_TICK: begin
                if (r_steps <= SW'(1)) begin
                    n_steps = '0;
                    ph_mid  = str_pkg::PH_STOP;
                end else begin
                    n_steps = r_steps - SW'(1);
                end
                n_pos   = r_fwd ? (r_pos + QW'(1)) : (r_pos - QW'(1));
                n_phase = ph_mid;
                unique case (ph_mid)
                    str_pkg::PH_ACCEL: begin
                        if ({1'b0, r_period} <= accel_floor) begin
                            n_period = r_target;
                            n_phase  = str_pkg::PH_STEADY;
                        end else begin
                            n_period = r_period - r_accel;
                        end
                        n_running = 1'b1;
                    end
                    str_pkg::PH_STEADY: begin
                        if (n_steps <= SW'(brake)) begin
                            n_phase = str_pkg::PH_DECEL;
                        end
                    end
                    str_pkg::PH_DECEL: begin
                        if (decel_sum >= {1'b0, L_STOP}) begin
                            n_period = L_STOP;
                            n_phase  = str_pkg::PH_STOP;
                        end else begin
                            n_period = decel_sum[PW-1:0];
                        end
                        n_running = 1'b1;
                    end
                    str_pkg::PH_STOP: begin
                        n_running = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            str_pkg::K_MOVE: begin
                n_steps   = r_count;
                n_period  = r_start;
                n_phase   = str_pkg::PH_ACCEL;
                n_running = 1'b1;
            end
            str_pkg::K_HARD_STOP: begin
                n_steps   = '0;
                n_period  = r_start;
                n_phase   = str_pkg::PH_IDLE;
                n_running = 1'b0;
            end
            str_pkg::K_SOFT_STOP: begin
                n_steps = SW'(brake);
            end
            str_pkg::K_SET_DIR: begin
                n_fwd = r_cmd_fwd;
            end
            str_pkg::K_LOAD_POS: begin
                n_pos = r_cmd_pos;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_start     <= str_pkg::RST_START_PERIOD;
            r_target    <= str_pkg::RST_TARGET_PERIOD;
            r_accel     <= str_pkg::RST_ACCEL_STEP;
            r_decel     <= str_pkg::RST_DECEL_STEP;
            r_steps     <= '0;
            r_period    <= str_pkg::RST_START_PERIOD;
            r_phase     <= str_pkg::PH_IDLE;
            r_fwd       <= 1'b1;
            r_pos       <= '0;
            r_running   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    str_pkg::REG_START_PERIOD:  r_start  <= i_cfg_data;
                    str_pkg::REG_TARGET_PERIOD: r_target <= i_cfg_data;
                    str_pkg::REG_ACCEL_STEP:    r_accel  <= i_cfg_data;
                    str_pkg::REG_DECEL_STEP:    r_decel  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            r_out_valid <= commit || (r_out_valid && i_out_stall);

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= needs_div ? S_DIV : S_APPLY;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    if (out_free) begin
                        r_state   <= S_IDLE;
                        r_steps   <= n_steps;
                        r_period  <= n_period;
                        r_phase   <= n_phase;
                        r_fwd     <= n_fwd;
                        r_pos     <= n_pos;
                        r_running <= n_running;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind    <= i_kind;
            r_count   <= i_step_count;
            r_cmd_fwd <= i_forward;
            r_cmd_pos <= i_position_value;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_period       = r_period;
    assign o_generator_on = r_running;
    assign o_phase        = r_phase;
    assign o_position     = r_pos;
    assign o_steps_left   = r_steps;
    assign o_cfg_ready    = 1'b1;

    // An idle motor never has the pulse generator running.
    a_idle_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == str_pkg::PH_IDLE) |-> !r_running)
        else $error("generator running while idle");

    // Acceleration is entered only by a move, which starts the generator.
    a_accel_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == str_pkg::PH_ACCEL) |-> r_running)
        else $error("generator off while accelerating");

    // The divider reports completion only while the controller waits for it.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside its wait state");

    // A committed transaction always leaves a result to be taken.
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_out_valid)
        else $error("commit without a pending result");

    // An accepted transaction keeps the input side stalled in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("input not stalled after a transaction");

endmodule

`default_nettype wire

// ===== verif/stepper_ramp_checker.sv =====
// ============================================================================
// stepper_ramp_checker
// Watches the command, result and register channels of the stepper ramp
// unit. It keeps its own copy of the ramp state, predicts the report of
// every accepted command, and compares each result transaction field by field
// with the oldest pending prediction.
// ============================================================================
`timescale 1ns / 1ps

module stepper_ramp_checker
    import str_pkg::*;
#(
    parameter int unsigned STOP_PERIOD = 64000
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [2:0]  i_kind,
    input  wire logic [30:0] i_step_count,
    input  wire logic        i_forward,
    input  wire logic [31:0] i_position_value,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [15:0] i_period,
    input  wire logic        i_generator_on,
    input  wire logic [2:0]  i_phase,
    input  wire logic [31:0] i_position,
    input  wire logic [30:0] i_steps_left,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [15:0] period;
        logic        generator_on;
        logic [2:0]  phase;
        logic [31:0] position;
        logic [30:0] steps_left;
    } t_motion_report;

    t_motion_report pending_reports[$];

    // Register copies.
    logic [15:0] start_per;
    logic [15:0] target_per;
    logic [15:0] accel_dec;
    logic [15:0] decel_inc;

    // Ramp state.
    logic [31:0] steps_rem;
    logic [31:0] cur_per;
    t_phase      motion;
    logic        dir_fwd;
    logic [31:0] step_pos;
    logic        gen_on;

    int fails = 0;

    function automatic logic [31:0] braking_distance(input logic [31:0] per_now,
                                                     input logic [15:0] inc);
        if (per_now >= STOP_PERIOD || inc == 16'd0) begin
            return 32'd0;
        end
        return (32'(STOP_PERIOD) - per_now) / 32'(inc);
    endfunction

    task automatic take_step();
        if (steps_rem <= 32'd1) begin
            steps_rem = 32'd0;
            motion    = PH_STOP;
        end else begin
            steps_rem = steps_rem - 32'd1;
        end
        step_pos = dir_fwd ? step_pos + 32'd1 : step_pos - 32'd1;

        case (motion)
            PH_ACCEL: begin
                if (cur_per <= 32'(target_per) + 32'(accel_dec)) begin
                    cur_per = 32'(target_per);
                    motion  = PH_STEADY;
                end else begin
                    cur_per = cur_per - 32'(accel_dec);
                end
                gen_on = 1'b1;
            end
            PH_STEADY: begin
                if (steps_rem <= braking_distance(cur_per, decel_inc)) begin
                    motion = PH_DECEL;
                end
            end
            PH_DECEL: begin
                cur_per = cur_per + 32'(decel_inc);
                if (cur_per >= STOP_PERIOD) begin
                    cur_per = 32'(STOP_PERIOD);
                    motion  = PH_STOP;
                end
                gen_on = 1'b1;
            end
            PH_STOP: gen_on = 1'b0;
            default: ;
        endcase
    endtask

    task automatic apply_command(input logic [2:0] kind, input logic [30:0] cnt,
                                 input logic fwd_in, input logic [31:0] pos_in);
        t_motion_report rep;
        case (kind)
            K_TICK: take_step();
            K_MOVE: begin
                steps_rem = {1'b0, cnt};
                cur_per   = 32'(start_per);
                motion    = PH_ACCEL;
                gen_on    = 1'b1;
            end
            K_HARD_STOP: begin
                steps_rem = 32'd0;
                motion    = PH_IDLE;
                cur_per   = 32'(start_per);
                gen_on    = 1'b0;
            end
            K_SOFT_STOP: steps_rem = braking_distance(cur_per, decel_inc);
            K_SET_DIR:   dir_fwd = fwd_in;
            K_LOAD_POS:  step_pos = pos_in;
            default: ;
        endcase
        rep.period       = cur_per[15:0];
        rep.generator_on = gen_on;
        rep.phase        = motion;
        rep.position     = step_pos;
        rep.steps_left   = steps_rem[30:0];
        pending_reports.push_back(rep);
    endtask

    task automatic check_report();
        t_motion_report exp;
        if (pending_reports.size() == 0) begin
            $error("unexpected result transaction: period %0d, phase %0d", i_period, i_phase);
            fails++;
            return;
        end
        exp = pending_reports.pop_front();
        if (i_period !== exp.period) begin
            $error("period: expected %0d, got %0d", exp.period, i_period);
            fails++;
        end
        if (i_generator_on !== exp.generator_on) begin
            $error("generator_on: expected %0d, got %0d", exp.generator_on, i_generator_on);
            fails++;
        end
        if (i_phase !== exp.phase) begin
            $error("phase: expected %0d, got %0d", exp.phase, i_phase);
            fails++;
        end
        if (i_position !== exp.position) begin
            $error("position: expected %0d, got %0d",
                   $signed(exp.position), $signed(i_position));
            fails++;
        end
        if (i_steps_left !== exp.steps_left) begin
            $error("steps_left: expected %0d, got %0d", exp.steps_left, i_steps_left);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_per  = RST_START_PERIOD;
            target_per = RST_TARGET_PERIOD;
            accel_dec  = RST_ACCEL_STEP;
            decel_inc  = RST_DECEL_STEP;
            steps_rem  = 32'd0;
            cur_per    = 32'(RST_START_PERIOD);
            motion     = PH_IDLE;
            dir_fwd    = 1'b1;
            step_pos   = 32'd0;
            gen_on     = 1'b0;
            pending_reports.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_START_PERIOD:  start_per  = i_cfg_data;
                    REG_TARGET_PERIOD: target_per = i_cfg_data;
                    REG_ACCEL_STEP:    accel_dec  = i_cfg_data;
                    REG_DECEL_STEP:    decel_inc  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                check_report();
            end
            if (i_in_valid && !i_in_stall) begin
                apply_command(i_kind, i_step_count, i_forward, i_position_value);
            end
        end
        o_pending    <= pending_reports.size();
        o_fail_count <= fails;
    end

endmodule

// ===== verif/tb_stepper_trapezoid_ramp_unit.sv =====
// ============================================================================
// tb_stepper_trapezoid_ramp_unit
// Drives the stepper ramp unit with directed commands under the reset
// register values, then with phases of random move sequences and single
// commands under extreme and random register settings, with random idling on
// both channels, one long output hold-off and one stretch without idling. A
// checker module predicts and compares every report.
// ============================================================================
`timescale 1ns / 1ps

module tb_stepper_trapezoid_ramp_unit;
    import str_pkg::*;

    localparam int unsigned STOP_PERIOD  = 64000;
    localparam int          ITEMS_TARGET = 1550;
    localparam int          N_PHASES     = 10;
    localparam int          HOLD_LEN     = 300;
    localparam int          CYCLE_LIMIT  = 600000;

    // Command codes the block leaves unused.
    localparam logic [2:0] K_SPARE_LO = 3'd6;
    localparam logic [2:0] K_SPARE_HI = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [2:0]  i_kind = K_TICK;
    logic [30:0] i_step_count = '0;
    logic        i_forward = 1'b0;
    logic [31:0] i_position_value = '0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [7:0]  i_cfg_index = REG_START_PERIOD;
    logic [15:0] i_cfg_data = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [15:0] o_period;
    logic        o_generator_on;
    logic [2:0]  o_phase;
    logic [31:0] o_position;
    logic [30:0] o_steps_left;
    logic        o_cfg_ready;

    int fail_count;
    int pending;
    int cmds_sent = 0;
    int cycle_count = 0;
    logic quiet = 1'b0;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;

    stepper_trapezoid_ramp_unit #(
        .STOP_PERIOD(STOP_PERIOD)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_step_count    (i_step_count),
        .i_forward       (i_forward),
        .i_position_value(i_position_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_period        (o_period),
        .o_generator_on  (o_generator_on),
        .o_phase         (o_phase),
        .o_position      (o_position),
        .o_steps_left    (o_steps_left),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    stepper_ramp_checker #(
        .STOP_PERIOD(STOP_PERIOD)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_step_count    (i_step_count),
        .i_forward       (i_forward),
        .i_position_value(i_position_value),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_period        (o_period),
        .i_generator_on  (o_generator_on),
        .i_phase         (o_phase),
        .i_position      (o_position),
        .i_steps_left    (o_steps_left),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off whenever one is asked.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_served != hold_asked) begin
            hold_served = hold_served + 1;
            hold_left = HOLD_LEN;
            i_out_stall <= 1'b1;
        end else if (quiet) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < 22);
        end
    end

    // Returns right after the acceptance edge with valid still high, so the
    // caller must offer the next command or drop valid in the same step.
    task automatic send_cmd(input logic [2:0] kind, input logic [30:0] cnt,
                            input logic fwd, input logic [31:0] pos);
        int unsigned gap;
        if (!quiet && $urandom_range(0, 99) < 22) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_kind           <= kind;
        i_step_count     <= cnt;
        i_forward        <= fwd;
        i_position_value <= pos;
        do @(posedge i_clk); while (o_in_stall);
        if (kind <= K_LOAD_POS) begin
            cmds_sent++;
        end
    endtask

    task automatic send_kind(input logic [2:0] kind);
        send_cmd(kind, 31'($urandom), 1'($urandom), $urandom);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic configure(input int ph);
        int unsigned st;
        int unsigned tg;
        int unsigned ac;
        int unsigned dc;
        case (ph)
            0: begin st = 1; tg = 1; ac = 1; dc = 1; end
            1: begin st = 65535; tg = 65535; ac = 65535; dc = 65535; end
            2: begin st = 20000; tg = 5000; ac = 3000; dc = 0; end
            3: begin st = 65535; tg = 60000; ac = 700; dc = 500; end
            4: begin st = 3000; tg = 1000; ac = 65535; dc = 9000; end
            default: begin
                tg = $urandom_range(1000, 40000);
                st = tg + $urandom_range(0, 20000);
                if (st > 65535) st = 65535;
                ac = $urandom_range(1, 4000);
                dc = $urandom_range(1, 8000);
            end
        endcase
        write_reg(REG_START_PERIOD, 16'(st));
        write_reg(REG_TARGET_PERIOD, 16'(tg));
        write_reg(REG_ACCEL_STEP, 16'(ac));
        write_reg(REG_DECEL_STEP, 16'(dc));
        // Writes past the last register must leave everything as it was.
        if (ph % 3 == 0) begin
            write_reg(8'($urandom_range(4, 255)), 16'($urandom));
        end
        i_cfg_valid <= 1'b0;
    endtask

    // A move followed by a run of ticks with a few other commands mixed in.
    task automatic move_sequence();
        logic [30:0] cnt;
        int unsigned n_ticks;
        int unsigned r;
        cnt = ($urandom_range(0, 99) < 88) ? 31'($urandom_range(0, 40)) : 31'($urandom);
        send_cmd(K_MOVE, cnt, 1'($urandom), $urandom);
        n_ticks = $urandom_range(0, 50);
        for (int k = 0; k < n_ticks; k++) begin
            r = $urandom_range(0, 99);
            if (r < 80)      send_kind(K_TICK);
            else if (r < 86) send_kind(K_SOFT_STOP);
            else if (r < 92) send_kind(K_SET_DIR);
            else if (r < 96) send_kind(K_LOAD_POS);
            else             send_kind(K_HARD_STOP);
        end
    endtask

    initial begin
        int phase_end;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed commands under the reset register values.
        send_kind(K_TICK);
        send_cmd(K_SET_DIR, 31'($urandom), 1'b0, $urandom);
        send_kind(K_TICK);
        send_kind(K_TICK);
        send_cmd(K_LOAD_POS, 31'($urandom), 1'($urandom), 32'h7FFF_FFFF);
        send_cmd(K_SET_DIR, 31'($urandom), 1'b1, $urandom);
        send_kind(K_TICK);
        send_cmd(K_LOAD_POS, 31'($urandom), 1'($urandom), 32'h8000_0000);
        send_cmd(K_SET_DIR, 31'($urandom), 1'b0, $urandom);
        send_kind(K_TICK);
        send_cmd(K_MOVE, 31'd0, 1'($urandom), $urandom);
        send_kind(K_TICK);
        send_kind(K_TICK);
        send_kind(K_SOFT_STOP);
        send_cmd(K_MOVE, 31'h7FFF_FFFF, 1'($urandom), $urandom);
        send_kind(K_TICK);
        send_kind(K_SOFT_STOP);
        send_kind(K_TICK);
        send_cmd(K_MOVE, 31'd5, 1'($urandom), $urandom);
        send_kind(K_TICK);
        send_kind(K_HARD_STOP);
        send_kind(K_SPARE_LO);
        send_kind(K_SPARE_HI);
        send_cmd(K_MOVE, 31'd1, 1'($urandom), 32'd0);
        send_kind(K_TICK);
        drain();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            configure(ph);
            if (ph == 6) quiet <= 1'b1;
            phase_end = cmds_sent + (ITEMS_TARGET - cmds_sent) / (N_PHASES - ph);
            while (cmds_sent < phase_end) begin
                // Hold the result side long enough for commands to back up.
                if (ph == 5 && hold_asked == 0 && cmds_sent > phase_end - 100) begin
                    hold_asked <= hold_asked + 1;
                end
                if ($urandom_range(0, 99) < 75) begin
                    move_sequence();
                end else begin
                    send_cmd(3'($urandom_range(0, 7)), 31'($urandom), 1'($urandom),
                             $urandom);
                end
            end
            drain();
            if (ph == 6) quiet <= 1'b0;
        end

        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
